// ===== rtl/scb_pkg.sv =====
`default_nettype none
package scb_pkg;

  localparam int LVL_W  = 14;
  localparam int PWR_W  = 23;
  localparam int REQ_W  = 24;
  localparam int BAND_W = 3;
  localparam int CFG_W  = 14;
  localparam int CFG_IDX_W = 2;
  // distance past an edge, magnitude
  localparam int DIST_W = 15;
  // product of power and distance
  localparam int PROD_W = PWR_W + DIST_W;
  localparam int DIV_CNT_W = 6;

  localparam logic [PWR_W-1:0] OUT_MAX = 23'd8388607;

  typedef enum logic [BAND_W-1:0] {
    BAND_FAR_BELOW = 3'd0,
    BAND_BELOW     = 3'd1,
    BAND_ON        = 3'd2,
    BAND_ABOVE     = 3'd3,
    BAND_FAR_ABOVE = 3'd4
  } band_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEAVE = 2'd0,
    CFG_ENTER = 2'd1,
    CFG_FAR   = 2'd2,
    CFG_DIV   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAND,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic [LVL_W-1:0] target_level;
    logic [LVL_W-1:0] measured_level;
    logic [PWR_W-1:0] charge_power;
    logic [PWR_W-1:0] discharge_power;
    logic             charge_off;
    logic             discharge_off;
  } scb_in_t;

  typedef struct packed {
    logic signed [REQ_W-1:0] power_request;
    logic [BAND_W-1:0]       band;
  } scb_out_t;

  typedef struct packed {
    logic load;
    logic band_en;
    logic mul_en;
    logic div_start;
    logic out_load;
  } scb_cmd_t;

  typedef struct packed {
    logic div_done;
  } scb_status_t;

endpackage
`default_nettype wire

// ===== rtl/scb_divider.sv =====
`default_nettype none
module scb_divider
  import scb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [CFG_W-1:0]  divisor,
  output logic [PROD_W-1:0]      quotient,
  output logic                   done
);

  logic [PROD_W-1:0]    q_r, q_nxt;
  logic [CFG_W:0]       rem_r, rem_nxt;
  logic [CFG_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CFG_W:0]       rem_sh;

  // restoring division, one quotient bit per cycle
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[CFG_W-1:0], q_r[PROD_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(PROD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        q_nxt   = {q_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[PROD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule
`default_nettype wire

// ===== rtl/scb_datapath.sv =====
`default_nettype none
module scb_datapath
  import scb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire scb_in_t              in_data,
  input  wire scb_cmd_t             cmd,
  output scb_status_t               status,
  output scb_out_t                  out_data
);

  logic [CFG_W-1:0] leave_r, enter_r, far_r, ramp_r;
  scb_in_t          item_r;
  band_t            band_r, band_nxt;
  logic [PWR_W-1:0] p_r;
  logic [DIST_W-1:0] x_r;
  logic             neg_r;
  logic [PROD_W-1:0] prod_r;
  scb_out_t         out_r, out_nxt;

  logic signed [LVL_W+2:0] t_s, m_s;
  logic signed [LVL_W+2:0] lv_lo, lv_hi, en_lo, en_hi, fa_lo, fa_hi;
  logic signed [LVL_W+2:0] d_above, d_below, d_sel;
  logic [CFG_W-1:0]  div_eff;
  logic [PROD_W-1:0] quo;
  logic              div_done;
  logic [PWR_W-1:0]  mag;
  logic [REQ_W-1:0]  mag_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leave_r <= '0;
      enter_r <= '0;
      far_r   <= '0;
      ramp_r  <= CFG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LEAVE: leave_r <= cfg_data;
        CFG_ENTER: enter_r <= cfg_data;
        CFG_FAR:   far_r   <= cfg_data;
        CFG_DIV:   ramp_r  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // band edges around the target
  always_comb begin
    t_s   = signed'({3'b000, item_r.target_level});
    m_s   = signed'({3'b000, item_r.measured_level});
    lv_lo = t_s - signed'({3'b000, leave_r});
    lv_hi = t_s + signed'({3'b000, leave_r});
    en_lo = t_s - signed'({3'b000, enter_r});
    en_hi = t_s + signed'({3'b000, enter_r});
    fa_lo = t_s - signed'({3'b000, far_r});
    fa_hi = t_s + signed'({3'b000, far_r});
  end

  // hysteresis band update
  always_comb begin
    band_nxt = band_r;
    case (band_r)
      BAND_FAR_ABOVE: begin
        if (m_s < fa_lo)      band_nxt = BAND_FAR_BELOW;
        else if (m_s < lv_lo) band_nxt = BAND_BELOW;
        else if (m_s < en_hi) band_nxt = BAND_ON;
        else if (m_s < fa_hi) band_nxt = BAND_ABOVE;
      end
      BAND_ABOVE: begin
        if (m_s > fa_hi)      band_nxt = BAND_FAR_ABOVE;
        else if (m_s < fa_lo) band_nxt = BAND_FAR_BELOW;
        else if (m_s < lv_lo) band_nxt = BAND_BELOW;
        else if (m_s < en_hi) band_nxt = BAND_ON;
      end
      BAND_BELOW: begin
        if (m_s > fa_hi)      band_nxt = BAND_FAR_ABOVE;
        else if (m_s > lv_hi) band_nxt = BAND_ABOVE;
        else if (m_s > en_lo) band_nxt = BAND_ON;
        else if (m_s < fa_lo) band_nxt = BAND_FAR_BELOW;
      end
      BAND_FAR_BELOW: begin
        if (m_s > fa_hi)      band_nxt = BAND_FAR_ABOVE;
        else if (m_s > lv_hi) band_nxt = BAND_ABOVE;
        else if (m_s > en_lo) band_nxt = BAND_ON;
        else if (m_s > fa_lo) band_nxt = BAND_BELOW;
      end
      default: begin
        if (m_s > fa_hi)      band_nxt = BAND_FAR_ABOVE;
        else if (m_s > lv_hi) band_nxt = BAND_ABOVE;
        else if (m_s < fa_lo) band_nxt = BAND_FAR_BELOW;
        else if (m_s < lv_lo) band_nxt = BAND_BELOW;
        else                  band_nxt = BAND_ON;
      end
    endcase
  end

  // ramp distances past the entering edge
  always_comb begin
    d_above = m_s - en_lo;
    d_below = en_hi - m_s;
    d_sel   = (band_nxt == BAND_ABOVE) ? d_above : d_below;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= BAND_ON;
    end else if (cmd.band_en) begin
      band_r <= band_nxt;
    end
  end

  // input capture, operand select, multiply
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.band_en) begin
      p_r   <= (band_nxt == BAND_ABOVE) ? item_r.discharge_power : item_r.charge_power;
      neg_r <= d_sel[LVL_W+2];
      x_r   <= d_sel[LVL_W+2] ? DIST_W'(-d_sel) : DIST_W'(d_sel);
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(p_r) * PROD_W'(x_r);
    end
  end

  assign div_eff = (ramp_r == '0) ? CFG_W'(1) : ramp_r;

  scb_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (div_eff),
    .quotient (quo),
    .done     (div_done)
  );

  assign status.div_done = div_done;

  // request from the new band; cap at the available power, else saturate
  always_comb begin
    if (!neg_r) begin
      mag = (quo > PROD_W'(p_r)) ? p_r : quo[PWR_W-1:0];
    end else begin
      mag = (quo > PROD_W'(OUT_MAX)) ? OUT_MAX : quo[PWR_W-1:0];
    end
    mag_ext = {1'b0, mag};
    out_nxt.band = band_r;
    out_nxt.power_request = '0;
    case (band_r)
      BAND_FAR_ABOVE: begin
        if (!item_r.discharge_off) out_nxt.power_request = {1'b0, item_r.discharge_power};
      end
      BAND_ABOVE: begin
        if (!item_r.discharge_off) begin
          out_nxt.power_request = neg_r ? -mag_ext : mag_ext;
        end
      end
      BAND_BELOW: begin
        if (!item_r.charge_off) begin
          out_nxt.power_request = neg_r ? mag_ext : -mag_ext;
        end
      end
      BAND_FAR_BELOW: begin
        if (!item_r.charge_off) out_nxt.power_request = -{1'b0, item_r.charge_power};
      end
      default: out_nxt.power_request = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== rtl/scb_ctrl.sv =====
`default_nettype none
module scb_ctrl
  import scb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire scb_status_t status,
  output scb_cmd_t         cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequencing: capture, band, multiply, divide, write result word
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_BAND;
        end
      end
      ST_BAND: begin
        cmd.band_en = 1'b1;
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_DIV_START;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/soc_band_charge_controller.sv =====
`default_nettype none
// Charge-level band controller. Each accepted word carries a target level, a measured
// level, the available charge and discharge power and two disable flags; it moves a
// five-band hysteresis state and returns one word with the signed power request and the
// new band. An item passes through capture, band update, multiply and divider start, then
// the restoring divider, which produces one quotient bit per cycle over the 38-bit
// power-distance product, then a hand-off state and the load of the output register. One
// item is in flight at a time; a new one is taken while the previous result still waits
// in the output register, and a result that is not taken holds the following item at the
// output stage. Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block itself does not enforce.
module soc_band_charge_controller
  import scb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire scb_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output scb_out_t                  out_data
);

  scb_cmd_t    cmd;
  scb_status_t status;

  scb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  scb_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import scb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 60;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RAND_PHASES     = 8;
  localparam int WORDS_PER_PHASE = 250;
  localparam int MAX_REPORTS     = 100;
  localparam longint REQ_LIMIT   = 8388607;
  localparam int LVL_TOP         = 16383;
  localparam int PWR_TOP         = 8388607;

  // band tracker and expected request queue
  class band_scoreboard;
    logic [CFG_W-1:0] leave_rng;
    logic [CFG_W-1:0] enter_rng;
    logic [CFG_W-1:0] far_rng;
    logic [CFG_W-1:0] ramp_div;
    band_t            cur_band;
    scb_out_t         expected_q[$];
    int               words_in;
    int               words_checked;
    int               errors;
    bit [4:0]         bands_seen;

    function new();
      leave_rng     = '0;
      enter_rng     = '0;
      far_rng       = '0;
      ramp_div      = CFG_W'(1);
      cur_band      = BAND_ON;
      words_in      = 0;
      words_checked = 0;
      errors        = 0;
      bands_seen    = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_LEAVE: leave_rng = val;
        CFG_ENTER: enter_rng = val;
        CFG_FAR:   far_rng = val;
        CFG_DIV:   ramp_div = val;
        default:   ;
      endcase
    endfunction

    // hysteresis move, each band checks its edges in a fixed order
    function band_t next_band(longint m, longint t);
      longint lv, en, fr;
      longint lv_lo, lv_hi, en_lo, en_hi, fa_lo, fa_hi;
      band_t nb;
      lv = leave_rng;
      en = enter_rng;
      fr = far_rng;
      lv_lo = t - lv;
      lv_hi = t + lv;
      en_lo = t - en;
      en_hi = t + en;
      fa_lo = t - fr;
      fa_hi = t + fr;
      nb = cur_band;
      case (cur_band)
        BAND_FAR_ABOVE: begin
          if (m < fa_lo) nb = BAND_FAR_BELOW;
          else if (m < lv_lo) nb = BAND_BELOW;
          else if (m < en_hi) nb = BAND_ON;
          else if (m < fa_hi) nb = BAND_ABOVE;
        end
        BAND_ABOVE: begin
          if (m > fa_hi) nb = BAND_FAR_ABOVE;
          else if (m < fa_lo) nb = BAND_FAR_BELOW;
          else if (m < lv_lo) nb = BAND_BELOW;
          else if (m < en_hi) nb = BAND_ON;
        end
        BAND_BELOW: begin
          if (m > fa_hi) nb = BAND_FAR_ABOVE;
          else if (m > lv_hi) nb = BAND_ABOVE;
          else if (m > en_lo) nb = BAND_ON;
          else if (m < fa_lo) nb = BAND_FAR_BELOW;
        end
        BAND_FAR_BELOW: begin
          if (m > fa_hi) nb = BAND_FAR_ABOVE;
          else if (m > lv_hi) nb = BAND_ABOVE;
          else if (m > en_lo) nb = BAND_ON;
          else if (m > fa_lo) nb = BAND_BELOW;
        end
        default: begin
          nb = BAND_ON;
          if (m > fa_hi) nb = BAND_FAR_ABOVE;
          else if (m > lv_hi) nb = BAND_ABOVE;
          else if (m < fa_lo) nb = BAND_FAR_BELOW;
          else if (m < lv_lo) nb = BAND_BELOW;
        end
      endcase
      return nb;
    endfunction

    // accepted input word: move the band and queue the expected request
    function void note_word(scb_in_t w);
      longint t, m, pc, pd, en, dv, req;
      scb_out_t e;
      t  = w.target_level;
      m  = w.measured_level;
      pc = w.charge_power;
      pd = w.discharge_power;
      en = enter_rng;
      dv = ramp_div;
      if (dv == 0) dv = 1;
      cur_band = next_band(m, t);
      req = 0;
      case (cur_band)
        BAND_FAR_ABOVE: begin
          if (!w.discharge_off) req = pd;
        end
        BAND_ABOVE: begin
          if (!w.discharge_off) begin
            req = (pd * (m - (t - en))) / dv;
            if (req > pd) req = pd;
          end
        end
        BAND_BELOW: begin
          if (!w.charge_off) begin
            req = -((pc * ((t + en) - m)) / dv);
            if (req < -pc) req = -pc;
          end
        end
        BAND_FAR_BELOW: begin
          if (!w.charge_off) req = -pc;
        end
        default: req = 0;
      endcase
      if (req > REQ_LIMIT) req = REQ_LIMIT;
      if (req < -REQ_LIMIT) req = -REQ_LIMIT;
      e.power_request = req[REQ_W-1:0];
      e.band = cur_band;
      expected_q.insert(expected_q.size(), e);
      words_in++;
      bands_seen[cur_band] = 1'b1;
    endfunction

    // accepted result word against the oldest expectation
    function void check_word(scb_out_t got);
      scb_out_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t result with no word waiting: request %0d band %0d",
                   $time, got.power_request, got.band);
        return;
      end
      e = expected_q.pop_front();
      words_checked++;
      if (got.power_request !== e.power_request) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t power_request: expected %0d, got %0d",
                   $time, e.power_request, got.power_request);
      end
      if (got.band !== e.band) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t band: expected %0d, got %0d", $time, e.band, got.band);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  cfg_idx_t         cfg_index = CFG_LEAVE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  scb_in_t          in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  scb_out_t         out_data;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int settings_done = 0;
  int walk_lvl = 5000;
  int walk_tgt = 5000;

  band_scoreboard sb = new();

  soc_band_charge_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random back pressure on the result side
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // handshake monitor
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_word(in_data);
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic scb_in_t mk_word(int t, int m, int pc, int pd, int c_off, int d_off);
    scb_in_t w;
    w.target_level    = LVL_W'(t);
    w.measured_level  = LVL_W'(m);
    w.charge_power    = PWR_W'(pc);
    w.discharge_power = PWR_W'(pd);
    w.charge_off      = (c_off != 0);
    w.discharge_off   = (d_off != 0);
    return w;
  endfunction

  function automatic int rand_power();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return 0;
    if (pick < 20) return PWR_TOP;
    if (pick < 50) return $urandom_range(1000);
    return $urandom_range(PWR_TOP);
  endfunction

  // measured level mostly drifts around the target so bands get held and crossed
  function automatic scb_in_t next_rand_word();
    int span, pick;
    span = int'(sb.far_rng) + 40;
    pick = $urandom_range(99);
    if (pick < 4) walk_tgt = $urandom_range(LVL_TOP);
    else if (pick < 8) walk_tgt = $urandom_range(10000);
    pick = $urandom_range(99);
    if (pick < 70) walk_lvl = walk_lvl + int'($urandom_range(span / 2)) - span / 4;
    else if (pick < 92) walk_lvl = walk_tgt + int'($urandom_range(2 * span)) - span;
    else walk_lvl = $urandom_range(LVL_TOP);
    if (walk_lvl < 0) walk_lvl = 0;
    if (walk_lvl > LVL_TOP) walk_lvl = LVL_TOP;
    return mk_word(walk_tgt, walk_lvl, rand_power(), rand_power(),
                   int'($urandom_range(4) == 0), int'($urandom_range(4) == 0));
  endfunction

  task automatic send_word(input scb_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input int lv, en, fr, dv);
    cfg_idx_t idx;
    logic [CFG_W-1:0] vals[4];
    vals = '{CFG_W'(lv), CFG_W'(en), CFG_W'(fr), CFG_W'(dv)};
    idx = CFG_LEAVE;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx;
      cfg_data <= vals[i];
      sb.write_reg(idx, vals[i]);
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  initial begin
    int lv, en, fr, dv;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero-width on band, unit divisor
    send_word(mk_word(5000, 5000, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 5001, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 4999, 1000, 1000, 0, 0));
    wait_drained();

    // directed walk through every band and several transitions between them
    program_regs(200, 100, 1000, 500);
    send_word(mk_word(5000, 5000, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 5150, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 5300, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 5120, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 5050, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 6500, 1000, PWR_TOP, 0, 0));
    send_word(mk_word(5000, 5500, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 3000, PWR_TOP, 1000, 0, 0));
    send_word(mk_word(5000, 4500, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 4850, 1000, 1000, 0, 0));
    send_word(mk_word(5000, 4950, 1000, 1000, 0, 0));
    // disabled directions still move the band
    send_word(mk_word(5000, 4700, 1000, 1000, 1, 0));
    send_word(mk_word(5000, 3500, 1000, 1000, 1, 0));
    send_word(mk_word(5000, 7000, 1000, 1000, 0, 1));
    send_word(mk_word(5000, 5400, 1000, 1000, 0, 1));
    // level and power extremes
    send_word(mk_word(0, 0, 0, 0, 0, 0));
    send_word(mk_word(LVL_TOP, LVL_TOP, PWR_TOP, PWR_TOP, 1, 1));
    send_word(mk_word(0, LVL_TOP, PWR_TOP, PWR_TOP, 0, 0));
    send_word(mk_word(LVL_TOP, 0, PWR_TOP, PWR_TOP, 0, 0));
    send_word(mk_word(5000, 5300, 1000, 0, 0, 0));
    // truncation toward zero on both signs
    send_word(mk_word(5000, 5300, 7, 7, 0, 0));
    send_word(mk_word(5000, 4700, 7, 7, 0, 0));
    send_word(mk_word(5000, 5300, 7, 7, 1, 1));
    wait_drained();

    // random phases, each with its own settings and one of four idle mixes
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin lv = 200;   en = 100;   fr = 1000;  dv = 500;   end
        1: begin lv = 0;     en = 0;     fr = 0;     dv = 0;     end
        2: begin lv = LVL_TOP; en = LVL_TOP; fr = LVL_TOP; dv = LVL_TOP; end
        3: begin lv = 50;    en = 300;   fr = 600;   dv = 1;     end
        4: begin lv = 1000;  en = 1000;  fr = 1000;  dv = 10000; end
        5: begin lv = 300;   en = 150;   fr = 5000;  dv = LVL_TOP; end
        6: begin
          lv = $urandom_range(LVL_TOP);
          en = $urandom_range(LVL_TOP);
          fr = $urandom_range(LVL_TOP);
          dv = $urandom_range(LVL_TOP);
        end
        default: begin lv = 10; en = 5; fr = 40; dv = 0; end
      endcase
      program_regs(lv, en, fr, dv);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      walk_tgt = $urandom_range(10000);
      walk_lvl = walk_tgt;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(next_rand_word());
        if (ph == 2 && n == WORDS_PER_PHASE / 2) wait_drained();
      end
      wait_drained();
    end

    $display("covered %0d input words over %0d register settings and four idle mixes",
             sb.words_in, settings_done);
    $display("checked %0d results, bands seen %b, %0d mismatches",
             sb.words_checked, sb.bands_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== soc_band_charge_controller.f =====
rtl/scb_pkg.sv
rtl/scb_divider.sv
rtl/scb_datapath.sv
rtl/scb_ctrl.sv
rtl/soc_band_charge_controller.sv
dv/testbench.sv
